// ===== design/mavlink_v1_frame_encoder_assert.svh =====
// Assertion macros used by the frame encoder back half.
`ifndef MAVLINK_V1_FRAME_ENCODER_ASSERT_SVH
`define MAVLINK_V1_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define MVE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define MVE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mve_pkg.sv =====
// Types, constants and the CRC step shared by the frame encoder modules.
package mve_pkg;

  localparam logic [7:0]  SOF_BYTE = 8'hFE;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SYSTEM_ID    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPONENT_ID = 8'd1;

  // Input request types.
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  // Byte positions within one queued command.
  localparam int unsigned STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_SOF  = 3'd0;
  localparam step_t STEP_LEN  = 3'd1;
  localparam step_t STEP_SEQ  = 3'd2;
  localparam step_t STEP_SYS  = 3'd3;
  localparam step_t STEP_COMP = 3'd4;
  localparam step_t STEP_MID  = 3'd5;
  localparam step_t HDR_BYTES = 3'd6;
  localparam step_t PLD_BYTES = 3'd1;

  // Command queue between the front and back halves.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       is_start;
    logic       finish;
    logic [7:0] len;
    logic [7:0] mid;
    logic [7:0] extra;
    logic [7:0] seq;
    logic [7:0] pbyte;
  } cmd_t;

  // One byte of CRC-16/MCRF4XX, reflected polynomial.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/mve_in_if.sv =====
// Input channel: frame start and payload byte requests.
interface mve_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] payload_length;
  logic [7:0] message_id;
  logic [7:0] crc_seed;
  logic [7:0] payload_byte;

  modport source (output valid, req_type, payload_length, message_id, crc_seed,
                  payload_byte, input ready);
  modport sink (input valid, req_type, payload_length, message_id, crc_seed,
                payload_byte, output ready);
endinterface

// ===== design/mve_out_if.sv =====
// Output channel: serialised frame bytes.
interface mve_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, tx_byte, run_last, frame_end, input ready);
  modport sink (input valid, tx_byte, run_last, frame_end, output ready);
endinterface

// ===== design/mve_cfg_if.sv =====
// Configuration write channel.
interface mve_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/mavlink_v1_frame_encoder.sv =====
// An accepted item passes through the command queue and the output byte register first.
// The emitter takes one payload item per cycle while the output is not stalled; a start item
// emits six bytes (eight for a zero-length frame) and a frame-closing payload item three.
// A four-entry command queue lets requests keep arriving while the emitter is busy.
// Reset (rst_n low, synchronous) closes any frame, zeroes the sequence and identifiers.
module mavlink_v1_frame_encoder (
  input  logic      clk,
  input  logic      rst_n,
  mve_in_if.sink    in_if,
  mve_out_if.source out_if,
  mve_cfg_if.sink   cfg_if
);

  logic          push_valid;
  mve_pkg::cmd_t push_cmd;
  logic          push_ready;
  logic          head_valid;
  mve_pkg::cmd_t head_cmd;
  logic          pop;

  mve_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  mve_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  mve_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_if  (cfg_if),
    .q_valid (head_valid),
    .q_cmd   (head_cmd),
    .q_pop   (pop),
    .out_if  (out_if)
  );

endmodule

// ===== design/mve_front.sv =====
// Front half: accepts requests, tracks frame state and queues byte commands.
module mve_front (
  input  logic              clk,
  input  logic              rst_n,
  mve_in_if.sink            in_if,
  output logic              push_valid,
  output mve_pkg::cmd_t     push_cmd,
  input  logic              push_ready
);

  logic       open_r, open_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] seq_r, seq_nxt;
  logic       accept;
  logic [7:0] left_dec;

  assign in_if.ready = push_ready;
  assign accept      = in_if.valid && push_ready;
  assign left_dec    = left_r - 8'd1;

  always_comb begin
    open_nxt   = open_r;
    left_nxt   = left_r;
    seq_nxt    = seq_r;
    push_valid = 1'b0;
    push_cmd.is_start = (in_if.req_type == mve_pkg::REQ_START);
    push_cmd.finish   = 1'b0;
    push_cmd.len      = in_if.payload_length;
    push_cmd.mid      = in_if.message_id;
    push_cmd.extra    = in_if.crc_seed;
    push_cmd.seq      = seq_r;
    push_cmd.pbyte    = in_if.payload_byte;
    if (accept) begin
      if (in_if.req_type == mve_pkg::REQ_START) begin
        // A new start simply abandons any open frame.
        push_valid = 1'b1;
        if (in_if.payload_length == 8'd0) begin
          push_cmd.finish = 1'b1;
          open_nxt        = 1'b0;
          left_nxt        = 8'd0;
          seq_nxt         = seq_r + 8'd1;
        end else begin
          open_nxt = 1'b1;
          left_nxt = in_if.payload_length;
        end
      end else if (open_r && left_r != 8'd0) begin
        push_valid = 1'b1;
        left_nxt   = left_dec;
        if (left_dec == 8'd0) begin
          push_cmd.finish = 1'b1;
          open_nxt        = 1'b0;
          seq_nxt         = seq_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      left_r <= 8'd0;
      seq_r  <= 8'd0;
    end else begin
      open_r <= open_nxt;
      left_r <= left_nxt;
      seq_r  <= seq_nxt;
    end
  end

endmodule

// ===== design/mve_queue.sv =====
// Short command queue between the front and back halves, head shown ahead of pop.
module mve_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  mve_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          head_valid,
  output mve_pkg::cmd_t head_cmd,
  input  logic          pop
);

  mve_pkg::cmd_t                  mem_r [mve_pkg::QDEPTH];
  logic [mve_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [mve_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [mve_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = (count_r != mve_pkg::QCNT_W'(mve_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/mve_back.sv =====
// Back half: expands queued commands into frame bytes and runs the CRC.
`include "mavlink_v1_frame_encoder_assert.svh"

module mve_back (
  input  logic          clk,
  input  logic          rst_n,
  mve_cfg_if.sink       cfg_if,
  input  logic          q_valid,
  input  mve_pkg::cmd_t q_cmd,
  output logic          q_pop,
  mve_out_if.source     out_if
);

  logic [7:0]     sys_id_r, comp_id_r;
  logic [15:0]    crc_r, crc_nxt;
  logic [7:0]     extra_r, extra_nxt;
  mve_pkg::step_t step_r, step_nxt;
  logic           out_valid_r;
  logic [7:0]     tx_byte_r;
  logic           run_last_r;
  logic           frame_end_r;

  logic           o_free;
  logic           emit;
  mve_pkg::step_t n_data;
  mve_pkg::step_t last_step;
  logic           is_data;
  logic           is_lo;
  logic           is_hi;
  logic [7:0]     data_byte;
  logic [7:0]     extra_sel;
  logic [7:0]     fold_in;
  logic [15:0]    fold_out;
  logic [7:0]     tx_sel;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_id_r  <= 8'd0;
      comp_id_r <= 8'd0;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == mve_pkg::REG_SYSTEM_ID) begin
        sys_id_r <= cfg_if.data;
      end else if (cfg_if.index == mve_pkg::REG_COMPONENT_ID) begin
        comp_id_r <= cfg_if.data;
      end
    end
  end

  assign o_free    = !out_valid_r || out_if.ready;
  assign emit      = q_valid && o_free;
  assign n_data    = q_cmd.is_start ? mve_pkg::HDR_BYTES : mve_pkg::PLD_BYTES;
  assign last_step = q_cmd.finish ? n_data + 3'd1 : n_data - 3'd1;
  assign is_data   = step_r < n_data;
  assign is_lo     = q_cmd.finish && (step_r == n_data);
  assign is_hi     = q_cmd.finish && (step_r == n_data + 3'd1);
  assign extra_sel = q_cmd.is_start ? q_cmd.extra : extra_r;
  assign q_pop     = emit && (step_r == last_step);

  always_comb begin
    data_byte = q_cmd.pbyte;
    if (q_cmd.is_start) begin
      unique case (step_r)
        mve_pkg::STEP_SOF:  data_byte = mve_pkg::SOF_BYTE;
        mve_pkg::STEP_LEN:  data_byte = q_cmd.len;
        mve_pkg::STEP_SEQ:  data_byte = q_cmd.seq;
        mve_pkg::STEP_SYS:  data_byte = sys_id_r;
        mve_pkg::STEP_COMP: data_byte = comp_id_r;
        mve_pkg::STEP_MID:  data_byte = q_cmd.mid;
        default:            data_byte = q_cmd.mid;
      endcase
    end
  end

  // At most one fold per emitted byte: a data byte after the start byte, or the held extra byte for the low CRC byte.
  assign fold_in  = is_data ? data_byte : extra_sel;
  assign fold_out = mve_pkg::crc_fold(crc_r, fold_in);

  always_comb begin
    if (is_data) begin
      tx_sel = data_byte;
    end else if (is_lo) begin
      tx_sel = fold_out[7:0];
    end else begin
      tx_sel = crc_r[15:8];
    end
  end

  always_comb begin
    crc_nxt   = crc_r;
    extra_nxt = extra_r;
    step_nxt  = step_r;
    if (emit) begin
      step_nxt = (step_r == last_step) ? mve_pkg::STEP_SOF : step_r + 3'd1;
      if (q_cmd.is_start && step_r == mve_pkg::STEP_SOF) begin
        crc_nxt   = mve_pkg::CRC_INIT;
        extra_nxt = q_cmd.extra;
      end else if (is_data || is_lo) begin
        crc_nxt = fold_out;
      end else begin
        crc_nxt = mve_pkg::CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= mve_pkg::CRC_INIT;
      extra_r     <= 8'd0;
      step_r      <= mve_pkg::STEP_SOF;
      out_valid_r <= 1'b0;
    end else begin
      crc_r   <= crc_nxt;
      extra_r <= extra_nxt;
      step_r  <= step_nxt;
      if (o_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tx_byte_r   <= tx_sel;
      run_last_r  <= (step_r == last_step);
      frame_end_r <= is_hi;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.tx_byte   = tx_byte_r;
  assign out_if.run_last  = run_last_r;
  assign out_if.frame_end = frame_end_r;

  `MVE_ASSERT_IMP(a_end_is_last, out_valid_r && frame_end_r, run_last_r, "frame end not last")
  `MVE_ASSERT_NXT(a_crc_rearm, emit && is_hi, crc_r == mve_pkg::CRC_INIT, "CRC not rearmed")
  `MVE_ASSERT_IMP(a_step_has_cmd, step_r != mve_pkg::STEP_SOF, q_valid, "step without command")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the MAVLink v1 frame encoder against predicted frame bytes.
module tb;

  localparam int QUIET_LIMIT    = 2000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 16;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       run_last;
    logic       frame_end;
  } frame_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  mve_in_if  in_ch ();
  mve_out_if out_ch ();
  mve_cfg_if cfg_ch ();

  mavlink_v1_frame_encoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Shadow of the encoder's state and identifier registers.
  logic [7:0]  seq_ctr;
  logic [7:0]  sys_id_q;
  logic [7:0]  comp_id_q;
  logic [7:0]  extra_held;
  logic [7:0]  bytes_to_go;
  logic [15:0] crc_run;
  logic        frame_is_open;

  frame_beat_t expected_beats[$];
  frame_beat_t item_beats[$];

  int mismatch_count;
  int in_xfers;
  int cfg_xfers;
  int quiet_cycles;
  bit tx_gaps;
  bit rx_gaps;
  bit rx_hold_pending;
  int rx_hold_left;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_mcrf_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int k = 0; k < 8; k++) begin
      fb  = acc[0] ^ b[k];
      acc = acc >> 1;
      if (fb) acc = acc ^ mve_pkg::CRC_POLY;
    end
    return acc;
  endfunction

  function automatic void stage_beat(logic [7:0] b, logic fend, logic fold);
    if (fold) crc_run = crc16_mcrf_step(crc_run, b);
    item_beats.push_back('{b, 1'b0, fend});
  endfunction

  function automatic void close_frame();
    crc_run = crc16_mcrf_step(crc_run, extra_held);
    stage_beat(crc_run[7:0], 1'b0, 1'b0);
    stage_beat(crc_run[15:8], 1'b1, 1'b0);
    seq_ctr       = seq_ctr + 8'd1;
    frame_is_open = 1'b0;
    bytes_to_go   = 8'd0;
    crc_run       = mve_pkg::CRC_INIT;
  endfunction

  function automatic void predict_frame_bytes(logic req, logic [7:0] len, logic [7:0] mid,
                                              logic [7:0] extra, logic [7:0] pb);
    item_beats.delete();
    if (req == mve_pkg::REQ_START) begin
      // A new start drops any unfinished frame, so its sequence number is reused.
      crc_run       = mve_pkg::CRC_INIT;
      extra_held    = extra;
      bytes_to_go   = len;
      frame_is_open = 1'b1;
      stage_beat(mve_pkg::SOF_BYTE, 1'b0, 1'b0);
      stage_beat(len, 1'b0, 1'b1);
      stage_beat(seq_ctr, 1'b0, 1'b1);
      stage_beat(sys_id_q, 1'b0, 1'b1);
      stage_beat(comp_id_q, 1'b0, 1'b1);
      stage_beat(mid, 1'b0, 1'b1);
      if (len == 8'd0) close_frame();
    end else if (frame_is_open && bytes_to_go != 8'd0) begin
      stage_beat(pb, 1'b0, 1'b1);
      bytes_to_go = bytes_to_go - 8'd1;
      if (bytes_to_go == 8'd0) close_frame();
    end
    if (item_beats.size() > 0) item_beats[item_beats.size() - 1].run_last = 1'b1;
    foreach (item_beats[k]) expected_beats.push_back(item_beats[k]);
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %02h got %02h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    frame_beat_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_xfers++;
        predict_frame_bytes(in_ch.req_type, in_ch.payload_length, in_ch.message_id,
                            in_ch.crc_seed, in_ch.payload_byte);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        cfg_xfers++;
        if (cfg_ch.index == mve_pkg::REG_SYSTEM_ID) sys_id_q = cfg_ch.data;
        else if (cfg_ch.index == mve_pkg::REG_COMPONENT_ID) comp_id_q = cfg_ch.data;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beats.size() == 0) begin
          mismatch_count++;
          $display("%0t: tx_byte expected nothing got %02h", $time, out_ch.tx_byte);
        end else begin
          want = expected_beats.pop_front();
          check_field("tx_byte", want.tx_byte, out_ch.tx_byte);
          check_field("run_last", 8'(want.run_last), 8'(out_ch.run_last));
          check_field("frame_end", 8'(want.frame_end), 8'(out_ch.frame_end));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Byte receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rx_hold_pending) begin
      rx_hold_pending = 1'b0;
      rx_hold_left    = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_gaps) begin
      out_ch.ready <= ($urandom_range(99) >= 25);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(logic req, logic [7:0] len, logic [7:0] mid, logic [7:0] extra,
                           logic [7:0] pb);
    int seen;
    while (tx_gaps && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    seen = in_xfers;
    in_ch.valid          <= 1'b1;
    in_ch.req_type       <= req;
    in_ch.payload_length <= len;
    in_ch.message_id     <= mid;
    in_ch.crc_seed       <= extra;
    in_ch.payload_byte   <= pb;
    do @(negedge clk); while (in_xfers == seen);
  endtask

  task automatic send_start(logic [7:0] len, logic [7:0] mid, logic [7:0] extra);
    send_item(mve_pkg::REQ_START, len, mid, extra, 8'($urandom()));
  endtask

  task automatic send_payload(logic [7:0] pb);
    send_item(mve_pkg::REQ_PAYLOAD, 8'($urandom()), 8'($urandom()), 8'($urandom()), pb);
  endtask

  // Stops driving requests, lets every expected byte out, then idles for a drain period.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [7:0] idx, logic [7:0] value);
    int seen;
    seen = cfg_xfers;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(negedge clk); while (cfg_xfers == seen);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    send_payload(8'h3C);
    send_start(8'd0, 8'h00, 8'h00);
    wait_idle();
  endtask

  task automatic test_id_extremes();
    cfg_write(mve_pkg::REG_SYSTEM_ID, 8'hFF);
    cfg_write(mve_pkg::REG_COMPONENT_ID, 8'hFF);
    send_start(8'd0, 8'hFF, 8'hFF);
    wait_idle();
    cfg_write(mve_pkg::REG_SYSTEM_ID, 8'h5A);
    cfg_write(mve_pkg::REG_COMPONENT_ID, 8'hA5);
  endtask

  task automatic test_short_frames();
    send_start(8'd1, 8'h01, 8'h32);
    send_payload(8'h00);
    send_start(8'd3, 8'h4C, 8'hD7);
    send_payload(8'hFF);
    send_payload(8'h80);
    send_payload(8'h01);
    // The frame is closed, so this byte must vanish.
    send_payload(8'h55);
    wait_idle();
  endtask

  task automatic test_abandoned_frame();
    send_start(8'd200, 8'h80, 8'h7F);
    repeat (3) send_payload(8'($urandom()));
    send_start(8'd2, 8'h21, 8'h9C);
    repeat (2) send_payload(8'($urandom()));
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_gaps         = 1'b0;
    rx_hold_pending = 1'b1;
    repeat (3) begin
      send_start(8'd8, 8'($urandom()), 8'($urandom()));
      repeat (8) send_payload(8'($urandom()));
    end
    tx_gaps = 1'b1;
    wait_idle();
  endtask

  task automatic test_sequence_wrap();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    repeat (258) send_start(8'd0, 8'($urandom()), 8'($urandom()));
    wait_idle();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic test_random_traffic(int budget);
    int sent;
    int pick;
    int len;
    int cut;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_payload(8'($urandom()));
        sent += 1;
      end else if (pick < 22) begin
        // Broken frame: cut short, to be dropped by the next start.
        len = $urandom_range(255, 1);
        cut = $urandom_range((len < 6) ? len - 1 : 5, 0);
        send_start(8'(len), 8'($urandom()), 8'($urandom()));
        repeat (cut) send_payload(8'($urandom()));
        sent += cut + 1;
      end else begin
        pick = $urandom_range(99);
        if (pick < 15) len = 0;
        else if (pick < 85) len = $urandom_range(12, 1);
        else len = $urandom_range(48, 13);
        send_start(8'(len), 8'($urandom()), 8'($urandom()));
        repeat (len) send_payload(8'($urandom()));
        sent += len + 1;
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.req_type       = mve_pkg::REQ_START;
    in_ch.payload_length = 8'd0;
    in_ch.message_id     = 8'd0;
    in_ch.crc_seed       = 8'd0;
    in_ch.payload_byte   = 8'd0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = mve_pkg::REG_SYSTEM_ID;
    cfg_ch.data          = 8'd0;
    tx_gaps              = 1'b1;
    rx_gaps              = 1'b1;
    rx_hold_pending      = 1'b0;
    rx_hold_left         = 0;
    mismatch_count       = 0;
    in_xfers             = 0;
    cfg_xfers            = 0;
    quiet_cycles         = 0;
    seq_ctr              = 8'd0;
    sys_id_q             = 8'd0;
    comp_id_q            = 8'd0;
    extra_held           = 8'd0;
    bytes_to_go          = 8'd0;
    crc_run              = mve_pkg::CRC_INIT;
    frame_is_open        = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_id_extremes();
    test_short_frames();
    test_abandoned_frame();
    test_backpressure();
    test_sequence_wrap();
    test_random_traffic(35);
    cfg_write(mve_pkg::REG_SYSTEM_ID, 8'h00);
    cfg_write(mve_pkg::REG_COMPONENT_ID, 8'h00);
    test_random_traffic(35);
    cfg_write(mve_pkg::REG_SYSTEM_ID, 8'($urandom()));
    cfg_write(mve_pkg::REG_COMPONENT_ID, 8'($urandom()));
    test_random_traffic(35);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/mve_pkg.sv
design/mve_in_if.sv
design/mve_out_if.sv
design/mve_cfg_if.sv
design/mve_front.sv
design/mve_queue.sv
design/mve_back.sv
design/mavlink_v1_frame_encoder.sv
tb/sv/tb.sv
